### hdl/assert_macros.svh
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("%m failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

### hdl/ptc_pkg.sv
// Package for the pressure and temperature compensation block.
`default_nettype none
package ptc_pkg;
  localparam int DivSteps = 32;
  localparam int Stages   = 9 + DivSteps;

  typedef enum logic [2:0] {
    CFG_T1_T2 = 3'd0,
    CFG_T3    = 3'd1,
    CFG_P1_P2 = 3'd2,
    CFG_P3_P4 = 3'd3,
    CFG_P5_P6 = 3'd4,
    CFG_P7_P8 = 3'd5,
    CFG_P9    = 3'd6
  } cfg_idx_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // Arithmetic right shift of a 32-bit word.
  function automatic logic [31:0] asr(input logic [31:0] x, input int n);
    return 32'($signed(x) >>> n);
  endfunction
endpackage
`default_nettype wire

### hdl/pressure_temperature_compensation_unit.sv
// Top level of the pressure and temperature compensation pipeline.
// A word is taken whenever start is high (busy is always low), and its result
// appears with out_valid after passing the six arithmetic stages, the 32-step
// restoring divider with one quotient bit per stage, two correction stages and
// the output register, one result per cycle at full rate. Results cannot be
// stalled.
// Calibration may only be rewritten while no word is in flight.
`default_nettype none
`include "assert_macros.svh"
module pressure_temperature_compensation_unit
  import ptc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [19:0] in_adc_temp,
  input  wire logic [19:0] in_adc_press,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output logic             out_valid,
  output logic [31:0]      out_temperature_centi,
  output logic [31:0]      out_pressure_pa,
  output logic             out_status
);
  logic [31:0] t1t2_r, p1p2_r, p3p4_r, p5p6_r, p7p8_r;
  logic [15:0] t3_r, p9_r;
  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1t2_r <= '0; t3_r <= '0; p1p2_r <= '0; p3p4_r <= '0;
      p5p6_r <= '0; p7p8_r <= '0; p9_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_T1_T2: t1t2_r <= cfg_data;
        CFG_T3:    t3_r   <= cfg_data[15:0];
        CFG_P1_P2: p1p2_r <= cfg_data;
        CFG_P3_P4: p3p4_r <= cfg_data;
        CFG_P5_P6: p5p6_r <= cfg_data;
        CFG_P7_P8: p7p8_r <= cfg_data;
        CFG_P9:    p9_r   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign t1 = {16'd0, t1t2_r[15:0]};
  assign t2 = sx16(t1t2_r[31:16]);
  assign t3 = sx16(t3_r);
  assign p1 = {16'd0, p1p2_r[15:0]};
  assign p2 = sx16(p1p2_r[31:16]);
  assign p3 = sx16(p3p4_r[15:0]);
  assign p4 = sx16(p3p4_r[31:16]);
  assign p5 = sx16(p5p6_r[15:0]);
  assign p6 = sx16(p5p6_r[31:16]);
  assign p7 = sx16(p7p8_r[15:0]);
  assign p8 = sx16(p7p8_r[31:16]);
  assign p9 = sx16(p9_r);

  assign busy = 1'b0;

  logic [Stages-1:0] v_r;

  // Stage 1: first temperature products.
  logic [31:0] s1_ta_r, s1_dd_r; logic [19:0] s1_ap_r;
  always_ff @(posedge clk) begin
    logic [31:0] d;
    d = {12'd0, in_adc_temp >> 4} - t1;
    s1_ta_r <= ({12'd0, in_adc_temp >> 3} - (t1 << 1)) * t2;
    s1_dd_r <= d * d;
    s1_ap_r <= in_adc_press;
  end

  // Stage 2: fine temperature.
  logic [31:0] s2_fine_r; logic [19:0] s2_ap_r;
  always_ff @(posedge clk) begin
    s2_fine_r <= asr(s1_ta_r, 11) + asr(asr(s1_dd_r, 12) * t3, 14);
    s2_ap_r   <= s1_ap_r;
  end

  // Stage 3: temperature result and the pressure offset square.
  logic [31:0] s3_temp_r, s3_a_r, s3_sq_r, s3_p2a_r; logic [19:0] s3_ap_r;
  always_ff @(posedge clk) begin
    logic [31:0] a, q;
    a = asr(s2_fine_r, 1) - 32'd64000;
    q = asr(a, 2);
    s3_temp_r <= asr(s2_fine_r * 32'd5 + 32'd128, 8);
    s3_a_r    <= a;
    s3_sq_r   <= q * q;
    s3_p2a_r  <= p2 * a;
    s3_ap_r   <= s2_ap_r;
  end

  // Stage 4: second-order terms.
  logic [31:0] s4_temp_r, s4_b6_r, s4_a5_r, s4_p3_r, s4_p2a_r; logic [19:0] s4_ap_r;
  always_ff @(posedge clk) begin
    s4_temp_r <= s3_temp_r;
    s4_b6_r   <= asr(s3_sq_r, 11) * p6;
    s4_a5_r   <= s3_a_r * p5;
    s4_p3_r   <= p3 * asr(s3_sq_r, 13);
    s4_p2a_r  <= s3_p2a_r;
    s4_ap_r   <= s3_ap_r;
  end

  // Stage 5: divisor product and offset sum.
  logic [31:0] s5_temp_r, s5_b_r, s5_div_r; logic [19:0] s5_ap_r;
  always_ff @(posedge clk) begin
    logic [31:0] b, a;
    b = s4_b6_r + (s4_a5_r << 1);
    b = asr(b, 2) + (p4 << 16);
    a = asr(asr(s4_p3_r, 3) + asr(s4_p2a_r, 1), 18);
    s5_temp_r <= s4_temp_r;
    s5_b_r    <= b;
    s5_div_r  <= (32'd32768 + a) * p1;
  end
  always_ff @(posedge clk) s5_ap_r <= s4_ap_r;

  // Restoring divider, one quotient bit per stage; slot 0 is stage 6.
  logic [31:0] dv_rem_r [DivSteps+1];
  logic [31:0] dv_num_r [DivSteps+1];
  logic [31:0] dv_den_r [DivSteps+1];
  logic [31:0] dv_tmp_r [DivSteps+1];
  logic        dv_dbl_r [DivSteps+1];

  // Stage 6: dividend and divisor for the divider.
  always_ff @(posedge clk) begin
    logic [31:0] p;
    p = ((32'd1048576 - {12'd0, s5_ap_r}) - asr(s5_b_r, 12)) * 32'd3125;
    dv_rem_r[0] <= '0;
    dv_tmp_r[0] <= s5_temp_r;
    dv_den_r[0] <= asr(s5_div_r, 15);
    dv_dbl_r[0] <= p[31];
    dv_num_r[0] <= p[31] ? p : (p << 1);
  end

  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    always_ff @(posedge clk) begin
      logic [32:0] r;
      logic [32:0] diff;
      r    = {dv_rem_r[i], dv_num_r[i][31]};
      diff = r - {1'b0, dv_den_r[i]};
      if (!diff[32]) dv_rem_r[i+1] <= diff[31:0];
      else           dv_rem_r[i+1] <= r[31:0];
      dv_num_r[i+1] <= {dv_num_r[i][30:0], ~diff[32]};
      dv_den_r[i+1] <= dv_den_r[i];
      dv_tmp_r[i+1] <= dv_tmp_r[i];
      dv_dbl_r[i+1] <= dv_dbl_r[i];
    end
  end

  // Final stages: fine correction of the pressure.
  logic [31:0] f1_p_r, f1_m_r, f1_p8_r, f1_t_r; logic f1_z_r;
  always_ff @(posedge clk) begin
    logic [31:0] p, p3s;
    p = dv_dbl_r[DivSteps] ? (dv_num_r[DivSteps] << 1) : dv_num_r[DivSteps];
    p3s = p >> 3;
    f1_p_r  <= p;
    f1_m_r  <= (p3s * p3s) >> 13;
    f1_p8_r <= (p >> 2) * p8;
    f1_t_r  <= dv_tmp_r[DivSteps];
    f1_z_r  <= (dv_den_r[DivSteps] == '0);
  end
  logic [31:0] f2_p_r, f2_a_r, f2_b_r, f2_t_r; logic f2_z_r;
  always_ff @(posedge clk) begin
    f2_p_r <= f1_p_r; f2_a_r <= asr(p9 * f1_m_r, 12); f2_b_r <= asr(f1_p8_r, 13);
    f2_t_r <= f1_t_r; f2_z_r <= f1_z_r;
  end
  always_ff @(posedge clk) begin
    out_temperature_centi <= f2_t_r;
    out_status            <= f2_z_r;
    out_pressure_pa       <= f2_z_r ? '0 : f2_p_r + asr(f2_a_r + f2_b_r + p7, 4);
  end

  logic [Stages-1:0] v_nxt;
  assign v_nxt = {v_r[Stages-2:0], start & ~busy};
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else        v_r <= v_nxt;
  end
  assign out_valid = v_r[Stages-1];

  `ASSERT_NEXT(a_flow, clk, rst_n, start, v_r[0])
  `ASSERT_IMPL(a_busy, clk, rst_n, !busy)
  `ASSERT_IMPL(a_zero, clk, rst_n, (out_valid && out_status) |-> (out_pressure_pa == '0))
endmodule
`default_nettype wire
